@@ hw/rtl/scaa_pkg.sv @@
// Shared types and constants for the sine/cosine approximator.
// No dependencies; imported by scaa_poly_pipe and sine_cosine_approximator_unit.
package scaa_pkg;

   // Field widths.
   localparam int AngleWidth = 8;
   localparam int ValueWidth = 10;
   localparam int BaseWidth  = 5;
   localparam int SqWidth    = 2 * BaseWidth;
   localparam int MagWidth   = 9;
   localparam int SineWidth  = 8;
   localparam int CorrWidth  = 12;
   localparam int EWidth     = 16;

   // Angle geometry in 1/200 turn units.
   localparam logic [AngleWidth-1:0] FullTurn     = 8'd200;
   localparam logic [AngleWidth-1:0] ThreeQuarter = 8'd150;
   localparam logic [AngleWidth-1:0] HalfTurn     = 8'd100;
   localparam logic [AngleWidth-1:0] QuarterTurn  = 8'd50;
   localparam logic [AngleWidth-1:0] SineMaxBase  = 8'd27;
   localparam logic [AngleWidth-1:0] CosMaxBase   = 8'd22;

   // Sine polynomial constants.
   localparam logic [6:0]           SineCubeMul = 7'd86;
   localparam logic [7:0]           SineRound   = 8'd128;
   localparam logic [CorrWidth-1:0] SineCorrOne = 12'd2048;
   localparam logic [6:0]           SineBias    = 7'd64;
   localparam int                   SineLinShift = 4;

   // Cosine polynomial constants.
   localparam logic [MagWidth-1:0]  CosOne   = 9'd256;
   localparam logic [2:0]           CosRound = 3'd4;
   localparam logic [BaseWidth-1:0] CosKnee  = 5'd16;

   // Folded angle: base-range argument, which polynomial, and the sign.
   typedef struct packed {
      logic [BaseWidth-1:0] base;
      logic                 use_sine;
      logic                 negate;
   } fold_type;

endpackage

@@ hw/rtl/sine_cosine_approximator_unit.sv @@
// Sine/cosine approximator: angle in 1/200 turn to sine*256 and cosine*256.
// Five register stages (fold, square, correction, product, sign select); rsp_valid travels with the data.
// Throughput: one request per clock; busy is always low, the five-stage pipeline never stalls.
// Reset (synchronous, active high) clears only the valid bits; data registers are not reset.
// Results are not held: each stays on rsp_* for the single cycle that rsp_valid marks.
// Depends on scaa_pkg and scaa_poly_pipe.
module sine_cosine_approximator_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [scaa_pkg::AngleWidth-1:0]           req_angle,
   output logic                                      rsp_valid,
   output logic signed [scaa_pkg::ValueWidth-1:0]    rsp_sine_value,
   output logic signed [scaa_pkg::ValueWidth-1:0]    rsp_cosine_value
);
   import scaa_pkg::*;

   // One fold stage plus four polynomial stages.
   localparam int Stages = 5;

   logic [AngleWidth-1:0] angle_wrapped;
   fold_type              sine_fold_ff;
   fold_type              sine_fold_in;
   fold_type              cos_fold_ff;
   fold_type              cos_fold_in;
   logic [Stages-1:0]     valid_ff;
   logic [Stages-1:0]     valid_in;

   function automatic fold_type make_fold(input logic [AngleWidth-1:0] diff,
                                          input logic use_sine,
                                          input logic negate);
      fold_type f;
      f.base     = diff[BaseWidth-1:0];
      f.use_sine = use_sine;
      f.negate   = negate;
      return f;
   endfunction

   // Sine by octant: each branch maps the angle onto a base range where
   // either the sine polynomial (0..27) or the cosine polynomial (0..22) holds.
   function automatic fold_type fold_sine(input logic [AngleWidth-1:0] x);
      fold_type f;
      if (x >= FullTurn - SineMaxBase) begin
         f = make_fold(FullTurn - x, 1'b1, 1'b1);
      end else if (x >= ThreeQuarter) begin
         f = make_fold(x - ThreeQuarter, 1'b0, 1'b1);
      end else if (x >= ThreeQuarter - CosMaxBase) begin
         f = make_fold(ThreeQuarter - x, 1'b0, 1'b1);
      end else if (x >= HalfTurn) begin
         f = make_fold(x - HalfTurn, 1'b1, 1'b1);
      end else if (x >= HalfTurn - SineMaxBase) begin
         f = make_fold(HalfTurn - x, 1'b1, 1'b0);
      end else if (x >= QuarterTurn) begin
         f = make_fold(x - QuarterTurn, 1'b0, 1'b0);
      end else if (x > SineMaxBase) begin
         f = make_fold(QuarterTurn - x, 1'b0, 1'b0);
      end else begin
         f = make_fold(x, 1'b1, 1'b0);
      end
      return f;
   endfunction

   // Cosine by octant, with the sine and cosine polynomials swapping roles.
   function automatic fold_type fold_cosine(input logic [AngleWidth-1:0] x);
      fold_type f;
      if (x >= FullTurn - CosMaxBase) begin
         f = make_fold(FullTurn - x, 1'b0, 1'b0);
      end else if (x >= ThreeQuarter) begin
         f = make_fold(x - ThreeQuarter, 1'b1, 1'b0);
      end else if (x >= ThreeQuarter - SineMaxBase) begin
         f = make_fold(ThreeQuarter - x, 1'b1, 1'b1);
      end else if (x >= HalfTurn) begin
         f = make_fold(x - HalfTurn, 1'b0, 1'b1);
      end else if (x >= HalfTurn - CosMaxBase) begin
         f = make_fold(HalfTurn - x, 1'b0, 1'b1);
      end else if (x >= QuarterTurn) begin
         f = make_fold(x - QuarterTurn, 1'b1, 1'b1);
      end else if (x > CosMaxBase) begin
         f = make_fold(QuarterTurn - x, 1'b1, 1'b0);
      end else begin
         f = make_fold(x, 1'b0, 1'b0);
      end
      return f;
   endfunction

   // The pipeline has no back-pressure, so a request is never refused.
   assign busy = 1'b0;

   // Angles past a full turn wrap once; 200 itself folds like 0.
   assign angle_wrapped = (req_angle > FullTurn) ? req_angle - FullTurn : req_angle;
   assign sine_fold_in  = fold_sine(angle_wrapped);
   assign cos_fold_in   = fold_cosine(angle_wrapped);

   // A request's valid bit moves one place per cycle alongside its data.
   assign valid_in = {valid_ff[Stages-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Folded arguments are registered before the polynomial pipelines.
   always_ff @(posedge clock) begin
      sine_fold_ff <= sine_fold_in;
      cos_fold_ff  <= cos_fold_in;
   end

   scaa_poly_pipe u_sine_pipe (
      .clock     (clock),
      .fold_in   (sine_fold_ff),
      .value_out (rsp_sine_value)
   );

   scaa_poly_pipe u_cos_pipe (
      .clock     (clock),
      .fold_in   (cos_fold_ff),
      .value_out (rsp_cosine_value)
   );

   assign rsp_valid = valid_ff[Stages-1];

endmodule

@@ hw/rtl/scaa_poly_pipe.sv @@
// Four-stage polynomial pipeline: square, correction, product, sign select.
// Depends on scaa_pkg for fold_type and the polynomial constants.
module scaa_poly_pipe (
   input  logic                                      clock,
   input  scaa_pkg::fold_type                        fold_in,
   output logic signed [scaa_pkg::ValueWidth-1:0]    value_out
);
   import scaa_pkg::*;

   // Stage A: square of the base argument.
   fold_type               fold_a_ff;
   logic [SqWidth-1:0]     sq_a_ff;
   logic [SqWidth-1:0]     sq_a_in;

   // Stage B: sine correction term and finished cosine magnitude.
   fold_type               fold_b_ff;
   logic [CorrWidth-1:0]   corr_b_ff;
   logic [CorrWidth-1:0]   corr_b_in;
   logic [MagWidth-1:0]    cos_b_ff;
   logic [MagWidth-1:0]    cos_b_in;
   logic [EWidth-1:0]      cube_prod;
   logic [SqWidth:0]       cos_sum;

   // Stage C: sine magnitude.
   fold_type               fold_c_ff;
   logic [SineWidth-1:0]   sin_c_ff;
   logic [SineWidth-1:0]   sin_c_in;
   logic [MagWidth-1:0]    cos_c_ff;
   logic [EWidth-1:0]      e_sum;

   // Stage D: signed result.
   logic [MagWidth-1:0]    mag_d;
   logic [ValueWidth-1:0]  value_d_ff;
   logic [ValueWidth-1:0]  value_d_in;

   assign sq_a_in = SqWidth'(fold_in.base) * SqWidth'(fold_in.base);

   // 86*sq + 128 stays below 2^16 over the whole base range.
   assign cube_prod = EWidth'(EWidth'(sq_a_ff) * EWidth'(SineCubeMul)) + EWidth'(SineRound);
   assign corr_b_in = SineCorrOne - CorrWidth'(cube_prod[EWidth-1:8]);

   assign cos_sum  = (SqWidth+1)'(sq_a_ff) + (SqWidth+1)'(CosRound);
   assign cos_b_in = CosOne - MagWidth'(cos_sum[SqWidth:3])
                     + MagWidth'(fold_a_ff.base > CosKnee);

   // e = x*corr + 64 + 16x, kept to 16 bits; the sine is its upper byte.
   assign e_sum = EWidth'(EWidth'(fold_b_ff.base) * EWidth'(corr_b_ff))
                  + EWidth'(SineBias)
                  + (EWidth'(fold_b_ff.base) << SineLinShift);
   assign sin_c_in = e_sum[EWidth-1:EWidth-SineWidth];

   assign mag_d      = fold_c_ff.use_sine ? MagWidth'(sin_c_ff) : cos_c_ff;
   assign value_d_in = fold_c_ff.negate ? ValueWidth'(-ValueWidth'(mag_d))
                                        : ValueWidth'(mag_d);

   always_ff @(posedge clock) begin
      fold_a_ff  <= fold_in;
      sq_a_ff    <= sq_a_in;
      fold_b_ff  <= fold_a_ff;
      corr_b_ff  <= corr_b_in;
      cos_b_ff   <= cos_b_in;
      fold_c_ff  <= fold_b_ff;
      sin_c_ff   <= sin_c_in;
      cos_c_ff   <= cos_b_ff;
      value_d_ff <= value_d_in;
   end

   assign value_out = signed'(value_d_ff);

endmodule
